### rtl/dashed_base32_key_decoder_macros.svh
// Assertion macros shared by the key decoder RTL.
// Used by dbkd_front and dbkd_back; empty bodies when SYNTH is defined.
`ifndef DASHED_BASE32_KEY_DECODER_MACROS_SVH
`define DASHED_BASE32_KEY_DECODER_MACROS_SVH

`ifndef SYNTH
`define DBKD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("dbkd assertion failed");
`define DBKD_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("dbkd forbidden condition");
`else
`define DBKD_ASSERT(lbl, clk, rstn, prop)
`define DBKD_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### rtl/dbkd_pkg.sv
// Shared constants, command type and symbol lookup for the key decoder.
// No dependencies.
`default_nettype none
package dbkd_pkg;

	localparam int KEY_TEXT_LEN = 41;
	localparam int KEY_SYMBOLS  = 36;
	localparam int KEY_BYTES    = 23;
	localparam int GROUP_SPAN   = 7;

	localparam int POS_W   = $clog2(KEY_TEXT_LEN + 1);
	localparam int SYM_W   = $clog2(KEY_SYMBOLS);
	localparam int SYMC_W  = $clog2(KEY_SYMBOLS + 1);
	localparam int COL_W   = $clog2(GROUP_SPAN);
	localparam int VAL_W   = 5;
	localparam int IDX_W   = $clog2(KEY_BYTES);
	localparam int ACC_W   = 12;
	localparam int CNT_W   = $clog2(ACC_W + 1);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_DASH  = 8'h2d;

	// One request from the front end: optional symbol write, optional finish.
	typedef struct packed {
		logic             wr;
		logic [SYM_W-1:0] addr;
		logic [VAL_W-1:0] value;
		logic             fin;
		logic             ok;
	} cmd_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
	} sym_t;

	function automatic sym_t symbol_lookup(input logic [7:0] c);
		logic [7:0] u;
		sym_t       r;
		u = c;
		r.hit = 1'b1;
		r.value = '0;
		if (c >= "a" && c <= "z")
			u = c - 8'd32;
		if (u >= "A" && u <= "H")
			r.value = VAL_W'(u - "A");
		else if (u >= "J" && u <= "N")
			r.value = VAL_W'(u - "J" + 8'd8);
		else if (u >= "P" && u <= "Z")
			r.value = VAL_W'(u - "P" + 8'd13);
		else if (u >= "1" && u <= "8")
			r.value = VAL_W'(u - "1" + 8'd24);
		else
			r.hit = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/dbkd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dbkd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/dbkd_front.sv
// Front end: takes characters, tracks blanks, groups and dashes, issues requests.
// Depends on dbkd_pkg and the assertion macro header.
`default_nettype none
`include "dashed_base32_key_decoder_macros.svh"
module dbkd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_of_text,
	output logic               cmd_valid,
	input  wire logic          cmd_ready,
	output dbkd_pkg::cmd_t     cmd
);
	import dbkd_pkg::*;

	typedef enum logic [2:0] {
		PH_LEAD = 3'b001,
		PH_BODY = 3'b010,
		PH_TAIL = 3'b100
	} phase_t;

	localparam logic [COL_W-1:0] COL_DASH = COL_W'(GROUP_SPAN - 1);

	phase_t             phase_q, phase_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [COL_W-1:0]   col_q, col_n;
	logic [SYMC_W-1:0]  symi_q, symi_n;
	logic               err_q, err_n;
	logic               blank, take, wr, accept;
	sym_t               sym;

	always_comb begin
		blank = char_code == CH_SPACE || char_code == CH_TAB;
		sym = symbol_lookup(char_code);
		phase_n = phase_q;
		pos_n = pos_q;
		col_n = col_q;
		symi_n = symi_q;
		err_n = err_q;
		wr = 1'b0;
		take = 1'b0;
		case (phase_q)
			PH_LEAD: begin
				if (!blank) begin
					phase_n = PH_BODY;
					take = 1'b1;
				end
			end
			PH_BODY: begin
				if (blank)
					phase_n = PH_TAIL;
				else
					take = 1'b1;
			end
			PH_TAIL: begin
				if (!blank)
					err_n = 1'b1;
			end
			default: begin
				err_n = 1'b1;
			end
		endcase
		if (take) begin
			if (pos_q >= POS_W'(KEY_TEXT_LEN)) begin
				err_n = 1'b1;
			end else begin
				if (col_q == COL_DASH) begin
					if (char_code != CH_DASH)
						err_n = 1'b1;
					col_n = '0;
				end else begin
					if (!sym.hit)
						err_n = 1'b1;
					else
						wr = 1'b1;
					col_n = col_q + 1'b1;
					symi_n = symi_q + 1'b1;
				end
				pos_n = pos_q + 1'b1;
			end
		end
	end

	assign in_ready  = cmd_ready;
	assign accept    = in_valid && cmd_ready;
	assign cmd_valid = in_valid && (wr || end_of_text);
	assign cmd.wr    = wr;
	assign cmd.addr  = SYM_W'(symi_q);
	assign cmd.value = sym.value;
	assign cmd.fin   = end_of_text;
	assign cmd.ok    = !err_n && phase_n != PH_LEAD && pos_n == POS_W'(KEY_TEXT_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pos_q <= '0;
			col_q <= '0;
			symi_q <= '0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				phase_q <= PH_LEAD;
				pos_q <= '0;
				col_q <= '0;
				symi_q <= '0;
				err_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q <= pos_n;
				col_q <= col_n;
				symi_q <= symi_n;
				err_q <= err_n;
			end
		end
	end

	`DBKD_ASSERT(a_pos_cap, clk, arst_n, pos_q <= POS_W'(KEY_TEXT_LEN))
	`DBKD_ASSERT(a_col_cap, clk, arst_n, col_q <= COL_DASH)
	`DBKD_ASSERT(a_restart, clk, arst_n, accept && end_of_text |=> pos_q == '0 && phase_q == PH_LEAD && !err_q)
	`DBKD_NEVER(a_wr_range, clk, arst_n, cmd_valid && cmd.wr && symi_q >= SYMC_W'(KEY_SYMBOLS))

endmodule
`default_nettype wire

### rtl/dbkd_queue.sv
// Two-entry request queue between front end and back end.
// Depends on dbkd_pkg.
`default_nettype none
module dbkd_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  dbkd_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  wire logic      out_ready,
	output dbkd_pkg::cmd_t out_cmd
);
	import dbkd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push, pop;

	assign in_ready  = count_q != CNT_QW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### rtl/dbkd_back.sv
// Back end: owns the symbol store, writes symbols and packs the 23 key bytes.
// Depends on dbkd_pkg, dbkd_ram and the assertion macro header.
`default_nettype none
`include "dashed_base32_key_decoder_macros.svh"
module dbkd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  dbkd_pkg::cmd_t         cmd,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             key_byte,
	output logic [dbkd_pkg::IDX_W-1:0] byte_index,
	output logic                   valid_key,
	output logic                   final_result
);
	import dbkd_pkg::*;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_BUILD = 3'b010,
		BK_LOAD  = 3'b100
	} back_state_t;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEY_BYTES - 1);

	back_state_t        state_q;
	logic [SYMC_W-1:0]  rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ACC_W-1:0]   acc_q;
	logic               m_valid_q, m_ok_q, m_last_q;
	logic [7:0]         m_byte_q;
	logic [IDX_W-1:0]   m_idx_q;
	logic               out_free, pop, re, emit, fail_emit, have_byte;
	logic [VAL_W-1:0]   rdata;
	logic [CNT_W-1:0]   shift;
	logic [7:0]         byte_sel;

	assign out_free  = !m_valid_q || out_ready;
	assign cmd_ready = state_q == BK_IDLE && (!cmd.fin || cmd.ok || out_free);
	assign pop       = cmd_valid && cmd_ready;
	assign fail_emit = pop && cmd.fin && !cmd.ok;
	assign have_byte = cnt_q >= CNT_W'(8);
	assign emit      = state_q == BK_BUILD && have_byte && out_free;
	assign re        = state_q == BK_BUILD && !have_byte && rd_q < SYMC_W'(KEY_SYMBOLS);
	assign shift     = cnt_q - CNT_W'(8);
	assign byte_sel  = 8'(acc_q >> shift);

	dbkd_ram #(.WIDTH(VAL_W), .DEPTH(KEY_SYMBOLS)) u_store (
		.clk   (clk),
		.we    (pop && cmd.wr),
		.waddr (cmd.addr),
		.wdata (cmd.value),
		.re    (re),
		.raddr (SYM_W'(rd_q)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rd_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (emit || fail_emit)
				m_valid_q <= 1'b1;
			else if (out_ready)
				m_valid_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					if (pop && cmd.fin && cmd.ok) begin
						rd_q <= '0;
						cnt_q <= CNT_W'(2);
						idx_q <= '0;
						state_q <= BK_BUILD;
					end
				end
				BK_BUILD: begin
					if (have_byte) begin
						if (out_free) begin
							cnt_q <= cnt_q - CNT_W'(8);
							idx_q <= idx_q + 1'b1;
							if (idx_q == IDX_LAST)
								state_q <= BK_IDLE;
						end
					end else if (re) begin
						rd_q <= rd_q + 1'b1;
						state_q <= BK_LOAD;
					end else begin
						// trailing pad: two zero bits after the last symbol
						cnt_q <= cnt_q + CNT_W'(2);
					end
				end
				BK_LOAD: begin
					cnt_q <= cnt_q + CNT_W'(VAL_W);
					state_q <= BK_BUILD;
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE)
			acc_q <= '0;
		else if (state_q == BK_LOAD)
			acc_q <= {acc_q[ACC_W-VAL_W-1:0], rdata};
		else if (state_q == BK_BUILD && !have_byte && !re)
			acc_q <= {acc_q[ACC_W-3:0], 2'b00};
		if (emit) begin
			m_byte_q <= byte_sel;
			m_idx_q <= idx_q;
			m_ok_q <= 1'b1;
			m_last_q <= idx_q == IDX_LAST;
		end else if (fail_emit) begin
			m_byte_q <= '0;
			m_idx_q <= '0;
			m_ok_q <= 1'b0;
			m_last_q <= 1'b1;
		end
	end

	assign out_valid    = m_valid_q;
	assign key_byte     = m_byte_q;
	assign byte_index   = m_idx_q;
	assign valid_key    = m_ok_q;
	assign final_result = m_last_q;

	`DBKD_ASSERT(a_cnt_cap, clk, arst_n, cnt_q <= CNT_W'(ACC_W))
	`DBKD_ASSERT(a_load_follows_read, clk, arst_n, state_q == BK_LOAD |-> $past(re))
	`DBKD_ASSERT(a_idx_range, clk, arst_n, m_valid_q |-> m_idx_q <= IDX_LAST)
	`DBKD_ASSERT(a_fail_single, clk, arst_n, m_valid_q && !m_ok_q |-> m_last_q && m_byte_q == '0)
	`DBKD_NEVER(a_rd_overrun, clk, arst_n, rd_q > SYMC_W'(KEY_SYMBOLS))

endmodule
`default_nettype wire

### rtl/dashed_base32_key_decoder.sv
// Top level: characters in, 23 decoded key bytes or one failure result out.
// Throughput: one character per cycle while the two-entry request queue has room.
// A bad key's failure result passes the request queue and the result register.
// A good key streams 23 bytes, paced by the store's single read port and the
// read/shift loop that each of the 36 symbols goes through.
// Reset (arst_n low) clears all control state; the symbol store is not cleared.
`default_nettype none
module dashed_base32_key_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire logic        s_axis_tlast,   // end_of_text
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] key_byte, [12:8] byte_index
	output logic             m_axis_tuser,   // [0] valid_key
	output logic             m_axis_tlast    // final_result
);
	import dbkd_pkg::*;

	logic             f_valid, f_ready, q_valid, q_ready;
	cmd_t             f_cmd, q_cmd;
	logic [7:0]       key_byte;
	logic [IDX_W-1:0] byte_index;

	dbkd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.char_code   (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd)
	);

	dbkd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	dbkd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.cmd          (q_cmd),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.key_byte     (key_byte),
		.byte_index   (byte_index),
		.valid_key    (m_axis_tuser),
		.final_result (m_axis_tlast)
	);

	assign m_axis_tdata = {(16 - 8 - IDX_W)'(0), byte_index, key_byte};

endmodule
`default_nettype wire

### tb/dashed_base32_key_decoder_tb.sv
// Self-checking bench for dashed_base32_key_decoder: streams key texts, predicts the bytes.
// The scoreboard class decodes each accepted text on its own; plain tasks drive the stream.
// Depends on dbkd_pkg and the decoder RTL.
module dashed_base32_key_decoder_tb;
	import dbkd_pkg::*;

	localparam string SYMBOL_SET   = "ABCDEFGHJKLMNPQRSTUVWXYZ12345678";
	localparam int    TOTAL_CHARS  = 210;
	localparam int    LONG_HOLD    = 300;
	localparam int    DRAIN_CYCLES = 150;
	localparam int    CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {SCAN_LEAD, SCAN_BODY, SCAN_TAIL} scan_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic [4:0] byte_index;
		logic       valid_key;
		logic       is_last;
	} key_result_t;

	class key_scoreboard;
		logic [4:0]  symbols[KEY_SYMBOLS];
		int          taken;
		scan_t       phase;
		bit          bad;
		key_result_t expected_q[$];
		int          errors, checked, good_keys, bad_keys, chars;

		function new();
			taken = 0;
			phase = SCAN_LEAD;
			bad = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB;
		endfunction

		function bit symbol_of(input logic [7:0] c, output logic [4:0] v);
			logic [7:0] up;
			up = (c >= "a" && c <= "z") ? c - 8'h20 : c;
			v = '0;
			for (int i = 0; i < 32; i++) begin
				if (SYMBOL_SET[i] == up) begin
					v = 5'(i);
					return 1;
				end
			end
			return 0;
		endfunction

		function void take_content(logic [7:0] c);
			logic [4:0] v;
			if (taken >= KEY_TEXT_LEN) begin
				bad = 1;
				return;
			end
			if (taken % GROUP_SPAN == GROUP_SPAN - 1) begin
				if (c != CH_DASH)
					bad = 1;
			end else if (!symbol_of(c, v)) begin
				bad = 1;
			end else begin
				symbols[taken - taken / GROUP_SPAN] = v;
			end
			taken++;
		endfunction

		function void note_input(logic [7:0] c, logic at_end);
			logic [8*KEY_BYTES-1:0] stream;
			bit                     good;
			chars++;
			case (phase)
				SCAN_LEAD: begin
					if (!is_blank(c)) begin
						phase = SCAN_BODY;
						take_content(c);
					end
				end
				SCAN_BODY: begin
					if (is_blank(c))
						phase = SCAN_TAIL;
					else
						take_content(c);
				end
				default: begin
					if (!is_blank(c))
						bad = 1;
				end
			endcase
			if (!at_end)
				return;
			good = !bad && phase != SCAN_LEAD && taken == KEY_TEXT_LEN;
			taken = 0;
			phase = SCAN_LEAD;
			bad = 0;
			if (!good) begin
				bad_keys++;
				expected_q.push_back('{8'h00, 5'd0, 1'b0, 1'b1});
				return;
			end
			good_keys++;
			// two zero bits, 180 symbol bits msb first, two zero bits
			stream = '0;
			for (int s = 0; s < KEY_SYMBOLS; s++)
				stream[8*KEY_BYTES-3-5*s -: 5] = symbols[s];
			for (int i = 0; i < KEY_BYTES; i++)
				expected_q.push_back('{stream[8*KEY_BYTES-1-8*i -: 8], 5'(i), 1'b1,
					i == KEY_BYTES - 1});
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(input logic [15:0] data, input logic user, input logic tl);
			key_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result data %h with nothing expected", data));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (data[7:0] !== want.key_byte)
				report_mismatch($sformatf("key_byte %h, expected %h (index %0d)",
					data[7:0], want.key_byte, want.byte_index));
			if (data[12:8] !== want.byte_index)
				report_mismatch($sformatf("byte_index %0d, expected %0d",
					data[12:8], want.byte_index));
			if (data[15:13] !== 3'b000)
				report_mismatch($sformatf("tdata pad bits %b not zero", data[15:13]));
			if (user !== want.valid_key)
				report_mismatch($sformatf("valid_key %b, expected %b", user, want.valid_key));
			if (tl !== want.is_last)
				report_mismatch($sformatf("final_result %b, expected %b (index %0d)",
					tl, want.is_last, want.byte_index));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] char_code
	logic        s_axis_tlast;   // end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [7:0] key_byte, [12:8] byte_index
	logic        m_axis_tuser;   // [0] valid_key
	logic        m_axis_tlast;   // final_result

	key_scoreboard sb;
	bit            calm;
	bit            long_hold_req;
	int            cycles;
	int            texts_sent;

	dashed_base32_key_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.expected_q.size());
			$display("FAIL dashed_base32_key_decoder");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// Result side: ready bursts, idle bursts, and one long hold on request.
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 0;
				m_axis_tready <= 1'b0;
				n = LONG_HOLD;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(1, 7);
			end else begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 12);
			end
			repeat (n) @(negedge clk);
		end
	end

	// Entered and left at a falling edge.
	task automatic drive_char(input logic [7:0] c, input logic at_end);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= at_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(c, at_end);
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] text[$]);
		for (int i = 0; i < text.size(); i++)
			drive_char(text[i], i == text.size() - 1);
		texts_sent++;
	endtask

	// fill < 0 picks random symbols
	function automatic void build_key(ref logic [7:0] text[$], input int fill,
			input bit mixed_case);
		logic [7:0] ch;
		for (int p = 0; p < KEY_TEXT_LEN; p++) begin
			if (p % GROUP_SPAN == GROUP_SPAN - 1) begin
				ch = CH_DASH;
			end else begin
				ch = SYMBOL_SET[fill < 0 ? $urandom_range(0, 31) : fill];
				if (mixed_case && ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
					ch = ch + 8'h20;
			end
			text.push_back(ch);
		end
	endfunction

	function automatic void add_blanks(ref logic [7:0] text[$], input int n, input bit front);
		logic [7:0] ch;
		for (int i = 0; i < n; i++) begin
			ch = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
			if (front)
				text.push_front(ch);
			else
				text.push_back(ch);
		end
	endfunction

	initial begin
		logic [7:0] text[$];
		int         kind;
		sb = new();
		calm = 0;
		long_hold_req = 0;
		cycles = 0;
		texts_sent = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: all-zero and all-ones symbol keys, blanks around the second
		text = {};
		build_key(text, 0, 0);
		send_text(text);
		text = {};
		build_key(text, 31, 0);
		add_blanks(text, 2, 1);
		add_blanks(text, 3, 0);
		send_text(text);
		// blank-only, byte zero and line feed texts
		send_text('{CH_SPACE});
		send_text('{CH_TAB, CH_SPACE, CH_TAB});
		send_text('{8'h00});
		send_text('{8'h0a});

		// back pressure: result side stalls long while a good key and a bad one are offered
		long_hold_req = 1;
		text = {};
		build_key(text, -1, 1);
		send_text(text);
		// non-blank after trailing blank
		text = {};
		build_key(text, -1, 0);
		text.push_back(CH_SPACE);
		text.push_back("A");
		send_text(text);

		while (sb.chars < TOTAL_CHARS) begin
			if (sb.chars >= TOTAL_CHARS * 3 / 4)
				calm = 1;
			text = {};
			kind = $urandom_range(0, 9);
			if (kind == 8) begin
				repeat ($urandom_range(1, 6))
					text.push_back(8'($urandom_range(0, 255)));
			end else begin
				build_key(text, -1, 1);
				case (kind)
					6: text[$urandom_range(0, KEY_TEXT_LEN - 1)] = 8'($urandom_range(0, 255));
					7: begin
						if ($urandom_range(0, 1))
							void'(text.pop_back());
						else
							text.push_back(SYMBOL_SET[$urandom_range(0, 31)]);
					end
					9: text.insert($urandom_range(1, KEY_TEXT_LEN - 2), CH_SPACE);
					default: ;
				endcase
				add_blanks(text, $urandom_range(0, 2), 1);
				add_blanks(text, $urandom_range(0, 2), 0);
			end
			send_text(text);
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d texts, %0d characters: %0d good keys, %0d rejected texts",
			texts_sent, sb.chars, sb.good_keys, sb.bad_keys);
		$display("checked %0d results with %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("PASS dashed_base32_key_decoder");
		else
			$display("FAIL dashed_base32_key_decoder");
		$finish;
	end
endmodule
